FILE: sv/assert_macros.svh
// Assertion macros shared by the ranging block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: sv/dstwr_pkg.sv
package dstwr_pkg;
  localparam int unsigned TimestampBits = 40;
  localparam int unsigned NumW = 65;
  localparam int unsigned DenW = 35;
  // One divider step per cell, plus sign fixup at the end.
  localparam int unsigned DivSteps = NumW - 1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_ZERODEN = 2'd2
  } status_e;

  // Word carried down the divider chain.
  typedef struct packed {
    logic                valid;
    logic [1:0]          status;
    logic                neg;
    logic [NumW-2:0]     quo;
    logic [DenW:0]       rem;
    logic [DenW-1:0]     den;
  } div_word_t;
endpackage

FILE: sv/dstwr_front.sv
module dstwr_front #(
  parameter int unsigned TsBits = dstwr_pkg::TimestampBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TsBits-1:0] own_tx_first_i,
  input  logic [TsBits-1:0] partner_rx_first_i,
  input  logic [TsBits-1:0] partner_tx_first_i,
  input  logic [TsBits-1:0] own_rx_first_i,
  input  logic [TsBits-1:0] own_tx_second_i,
  input  logic [TsBits-1:0] partner_rx_second_i,
  input  logic [7:0]        present_mask_i,
  output dstwr_pkg::div_word_t word_o
);
  import dstwr_pkg::*;

  // The difference is formed at 64 bits so that narrow timestamps still
  // yield a full 32-bit interval.
  function automatic logic [31:0] wrap_iv(logic [TsBits-1:0] later,
                                          logic [TsBits-1:0] earlier);
    logic [63:0] d;
    begin
      if (later < earlier) d = 64'({TsBits{1'b1}} - earlier) + 64'(later);
      else d = 64'(later - earlier);
      wrap_iv = d[31:0];
    end
  endfunction

  // Stage 1: intervals and validity.
  logic        v1_q;
  logic [1:0]  st1_q;
  logic signed [31:0] ra_q, da_q, rb_q, db_q;
  // Stage 2: products and denominator.
  logic        v2_q;
  logic [1:0]  st2_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [DenW-1:0] den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q <= (present_mask_i == 8'hFF) ? ST_OK : ST_MISSING;
    ra_q  <= wrap_iv(own_rx_first_i, own_tx_first_i);
    da_q  <= wrap_iv(own_tx_second_i, own_rx_first_i);
    rb_q  <= wrap_iv(partner_rx_second_i, partner_tx_first_i);
    db_q  <= wrap_iv(partner_tx_first_i, partner_rx_first_i);
    p1_q  <= 64'(ra_q) * 64'(rb_q);
    p2_q  <= 64'(da_q) * 64'(db_q);
    den2_q <= DenW'(ra_q) + DenW'(rb_q) + DenW'(da_q) + DenW'(db_q);
    st2_q <= st1_q;
  end

  logic signed [NumW-1:0] num;
  logic [NumW-1:0] num_abs;
  logic [DenW-1:0] den_abs;
  logic            zden;
  assign num     = NumW'(p1_q) - NumW'(p2_q);
  assign num_abs = num[NumW-1] ? NumW'(-num) : NumW'(num);
  assign den_abs = den2_q[DenW-1] ? DenW'(-den2_q) : DenW'(den2_q);
  assign zden    = (den2_q == '0);

  // num fits in 64 magnitude bits, so the quotient field takes them all and the remainder starts at zero.
  always_comb begin
    word_o.valid  = v2_q;
    word_o.status = (st2_q != ST_OK) ? st2_q : (zden ? ST_ZERODEN : ST_OK);
    word_o.neg    = num[NumW-1] ^ den2_q[DenW-1];
    word_o.quo    = num_abs[NumW-2:0];
    word_o.rem    = '0;
    word_o.den    = den_abs;
  end
endmodule

FILE: sv/dstwr_cell.sv
module dstwr_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dstwr_pkg::div_word_t word_i,
  output dstwr_pkg::div_word_t word_o
);
  import dstwr_pkg::*;

  // One restoring division step: shift in the next dividend bit.
  logic [DenW:0] sh;
  logic [DenW+1:0] diff;
  div_word_t w_d, w_q;
  logic valid_q;

  always_comb begin
    sh   = {word_i.rem[DenW-1:0], word_i.quo[NumW-2]};
    diff = {1'b0, sh} - {2'b0, word_i.den};
    w_d  = word_i;
    if (!diff[DenW+1]) begin
      w_d.rem = diff[DenW:0];
    end else begin
      w_d.rem = sh;
    end
    w_d.quo = {word_i.quo[NumW-3:0], ~diff[DenW+1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  // Only the valid flag is reset; it overrides the stored copy.
  always_comb begin
    word_o       = w_q;
    word_o.valid = valid_q;
  end
endmodule

FILE: sv/ds_twr_propagation_time.sv
// Double-sided two-way ranging, propagation time of one exchange.
// Drive start high with the eight timestamps and present_mask_i for one
// cycle; busy is always low, so a new word is taken on every clock edge.
// Two front stages form the four wrapped intervals, then the products and
// denominator. A chain of 64 identical cells then divides the magnitude of
// the numerator by the magnitude of the denominator, one quotient bit per
// cell, and a last stage restores the sign and truncates to 32 bits.
// done_o rises once the word has passed the front stages and the cell chain
// into the output register. Throughput is one word per cycle. The result
// appears on propagation_time_o and status_o for exactly one cycle with
// done_o high; the receiver cannot stall it. Status 1 means a timestamp
// was missing, 2 a zero denominator; the time is zero in both cases. Reset
// clears all valid flags in the pipeline; nothing in flight survives reset.
`include "assert_macros.svh"
module ds_twr_propagation_time #(
  parameter int unsigned TIMESTAMP_BITS = dstwr_pkg::TimestampBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [TIMESTAMP_BITS-1:0] own_tx_first_i,
  input  logic [TIMESTAMP_BITS-1:0] partner_rx_first_i,
  input  logic [TIMESTAMP_BITS-1:0] partner_tx_first_i,
  input  logic [TIMESTAMP_BITS-1:0] own_rx_first_i,
  input  logic [TIMESTAMP_BITS-1:0] own_tx_second_i,
  input  logic [TIMESTAMP_BITS-1:0] partner_rx_second_i,
  input  logic [TIMESTAMP_BITS-1:0] partner_tx_second_i,
  input  logic [TIMESTAMP_BITS-1:0] own_rx_second_i,
  input  logic [7:0]                present_mask_i,
  output logic                      done_o,
  output logic signed [31:0]        propagation_time_o,
  output logic [1:0]                status_o
);
  import dstwr_pkg::*;

  div_word_t chain [DivSteps+1];
  logic      acc;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // The second-round partner tx and own rx stamps only count for presence.
  logic unused_ts;
  assign unused_ts = ^{partner_tx_second_i, own_rx_second_i};

  dstwr_front #(.TsBits(TIMESTAMP_BITS)) u_front (
    .clk_i, .rst_ni, .start_i(acc),
    .own_tx_first_i, .partner_rx_first_i, .partner_tx_first_i,
    .own_rx_first_i, .own_tx_second_i, .partner_rx_second_i,
    .present_mask_i, .word_o(chain[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_cell
    dstwr_cell u_cell (.clk_i, .rst_ni, .word_i(chain[g]), .word_o(chain[g+1]));
  end

  logic done_q;
  logic signed [31:0] pt_q;
  logic [1:0] st_q;
  div_word_t last;
  assign last = chain[DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= last.status;
    if (last.status != ST_OK) begin
      pt_q <= '0;
    end else if (last.neg) begin
      pt_q <= 32'(-last.quo[31:0] + unused_ts - unused_ts);
    end else begin
      pt_q <= last.quo[31:0];
    end
  end

  assign done_o             = done_q;
  assign propagation_time_o = pt_q;
  assign status_o           = st_q;

  `ASSERT_IMPL(a_busy_low, clk_i, rst_ni, 1'b1, !busy)
  `ASSERT_IMPL(a_zero_on_err, clk_i, rst_ni, done_o && status_o != ST_OK, propagation_time_o == 0)
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, done_o, status_o != 2'd3)
  `ASSERT_NEXT(a_done_follows, clk_i, rst_ni, last.valid, done_o)
endmodule
